// ===== design/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the key click classifier: phase codes,
// event codes, register indexes, the per-key record and the config bundle.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int NUM_KEYS = 4;

	localparam int KEY_W   = 2;
	localparam int TIME_W  = 32;
	localparam int MS_W    = 16;
	localparam int MASK_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		PH_RELEASED    = 3'd0,
		PH_PRESS_DEB   = 3'd1,
		PH_PRESSED     = 3'd2,
		PH_RELEASE_DEB = 3'd3,
		PH_WAIT_DOUBLE = 3'd4,
		PH_DOUBLE_DEB  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SHORT  = 2'd1,
		EV_LONG   = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_LOW_MASK = 3'd0,
		CFG_DEBOUNCE_MS     = 3'd1,
		CFG_LONG_PRESS_MS   = 3'd2,
		CFG_SHORT_MIN_MS    = 3'd3,
		CFG_DOUBLE_CLICK_MS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [MASK_W-1:0] active_low_mask;
		logic [MS_W-1:0]   debounce_ms;
		logic [MS_W-1:0]   long_press_ms;
		logic [MS_W-1:0]   short_min_ms;
		logic [MS_W-1:0]   double_click_ms;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic              stable_pressed;
		logic              candidate_pressed;
		logic [TIME_W-1:0] debounce_start;
		logic [TIME_W-1:0] press_start;
		logic [TIME_W-1:0] release_time;
		logic              long_done;
		logic              suppress_release;
	} key_rec_t;

	localparam key_rec_t KEY_REC_RESET = '{
		phase:             PH_RELEASED,
		stable_pressed:    1'b0,
		candidate_pressed: 1'b0,
		debounce_start:    '0,
		press_start:       '0,
		release_time:      '0,
		long_done:         1'b0,
		suppress_release:  1'b0
	};

endpackage

// ===== design/kcc_in_if.sv =====
// ----------------------------------------------------------------------------
// kcc_in_if
// Scan sample channel: one beat is one pin sample of one key.
// ----------------------------------------------------------------------------
interface kcc_in_if import kcc_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_index;
	logic              pin_level;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, output key_index, output pin_level, output time_ms,
		input ready);
	modport sink (input valid, input key_index, input pin_level, input time_ms,
		output ready);

endinterface

// ===== design/kcc_out_if.sv =====
// ----------------------------------------------------------------------------
// kcc_out_if
// Result channel: one beat is the event and debounced level of one key.
// ----------------------------------------------------------------------------
interface kcc_out_if import kcc_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_out;
	logic [1:0]       event_res;
	logic             is_pressed;

	modport source (output valid, output key_out, output event_res, output is_pressed,
		input ready);
	modport sink (input valid, input key_out, input event_res, input is_pressed,
		output ready);

endinterface

// ===== design/kcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kcc_cfg_regs
// Configuration register file; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
module kcc_cfg_regs import kcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low_mask <= '0;
			cfg_q.debounce_ms     <= MS_W'(20);
			cfg_q.long_press_ms   <= MS_W'(1000);
			cfg_q.short_min_ms    <= MS_W'(50);
			cfg_q.double_click_ms <= MS_W'(300);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_LOW_MASK: cfg_q.active_low_mask <= cfg_data[MASK_W-1:0];
				CFG_DEBOUNCE_MS:     cfg_q.debounce_ms     <= cfg_data[MS_W-1:0];
				CFG_LONG_PRESS_MS:   cfg_q.long_press_ms   <= cfg_data[MS_W-1:0];
				CFG_SHORT_MIN_MS:    cfg_q.short_min_ms    <= cfg_data[MS_W-1:0];
				CFG_DOUBLE_CLICK_MS: cfg_q.double_click_ms <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/kcc_key_step.sv =====
// ----------------------------------------------------------------------------
// kcc_key_step
// Next-record logic of one key: debounce, long press, short press and
// double click decisions for a single sample.
// ----------------------------------------------------------------------------
module kcc_key_step import kcc_pkg::*; (
	input  key_rec_t          rec,
	input  logic              lvl,
	input  logic [TIME_W-1:0] now,
	input  cfg_t              cfg,
	output key_rec_t          rec_nxt,
	output event_t            ev
);

	logic [TIME_W-1:0] deb_elapsed;
	logic [TIME_W-1:0] press_elapsed;
	logic [TIME_W-1:0] rel_elapsed;
	logic              deb_done;
	logic              long_hit;
	logic              short_ok;
	logic              window_over;

	assign deb_elapsed   = now - rec.debounce_start;
	assign press_elapsed = now - rec.press_start;
	assign rel_elapsed   = now - rec.release_time;

	assign deb_done    = deb_elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.debounce_ms};
	assign long_hit    = press_elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.long_press_ms};
	assign short_ok    = press_elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.short_min_ms};
	assign window_over = rel_elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.double_click_ms};

	always_comb begin
		rec_nxt = rec;
		ev      = EV_NONE;
		unique case (rec.phase)
			PH_RELEASED: begin
				if (lvl) begin
					rec_nxt.candidate_pressed = 1'b1;
					rec_nxt.debounce_start    = now;
					rec_nxt.phase             = PH_PRESS_DEB;
				end
			end
			PH_PRESS_DEB: begin
				if (lvl != rec.candidate_pressed) begin
					rec_nxt.phase = PH_RELEASED;
				end else if (deb_done) begin
					rec_nxt.stable_pressed   = 1'b1;
					rec_nxt.press_start      = now;
					rec_nxt.long_done        = 1'b0;
					rec_nxt.suppress_release = 1'b0;
					rec_nxt.phase            = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!lvl) begin
					rec_nxt.candidate_pressed = 1'b0;
					rec_nxt.debounce_start    = now;
					rec_nxt.phase             = PH_RELEASE_DEB;
				end else if (!rec.long_done && long_hit) begin
					rec_nxt.long_done = 1'b1;
					ev                = EV_LONG;
				end
			end
			PH_RELEASE_DEB: begin
				if (lvl != rec.candidate_pressed) begin
					rec_nxt.phase = PH_PRESSED;
				end else if (deb_done) begin
					rec_nxt.stable_pressed = 1'b0;
					rec_nxt.release_time   = now;
					if (rec.long_done || rec.suppress_release) begin
						rec_nxt.suppress_release = 1'b0;
						rec_nxt.phase            = PH_RELEASED;
					end else if (short_ok) begin
						rec_nxt.phase = PH_WAIT_DOUBLE;
					end else begin
						rec_nxt.phase = PH_RELEASED;
					end
				end
			end
			PH_WAIT_DOUBLE: begin
				if (window_over) begin
					ev            = EV_SHORT;
					rec_nxt.phase = PH_RELEASED;
				end else if (lvl) begin
					rec_nxt.candidate_pressed = 1'b1;
					rec_nxt.debounce_start    = now;
					rec_nxt.phase             = PH_DOUBLE_DEB;
				end
			end
			PH_DOUBLE_DEB: begin
				if (lvl != rec.candidate_pressed) begin
					rec_nxt.phase = PH_WAIT_DOUBLE;
				end else if (deb_done) begin
					ev                       = EV_DOUBLE;
					rec_nxt.stable_pressed   = 1'b1;
					rec_nxt.press_start      = now;
					rec_nxt.long_done        = 1'b0;
					rec_nxt.suppress_release = 1'b1;
					rec_nxt.phase            = PH_PRESSED;
				end
			end
			default: begin
				rec_nxt.phase          = PH_RELEASED;
				rec_nxt.stable_pressed = 1'b0;
			end
		endcase
	end

endmodule

// ===== design/key_click_classifier.sv =====
// ----------------------------------------------------------------------------
// key_click_classifier
// Per-key debounce and click classifier: short press, long press and
// double click events from timestamped pin samples of up to NUM_KEYS keys.
// ----------------------------------------------------------------------------
// channel | dir | beat
// in_ch   | in  | key_index, pin_level, time_ms (one pin sample)
// out_ch  | out | key_out, event_res, is_pressed (one result per sample)
// cfg     | in  | cfg_we, cfg_index, cfg_data (register write, no read-back)
//
// one sample per cycle while out_ch is not stalled; the sample is registered
// in stage 1 and its result beat in stage 2, which drives out_ch
// stage 1 registers the sample, the key record update and the result
// register are written at the same edge, so back-to-back samples of one
// key see the updated record
// output stall holds both stages; in_ch.ready drops only when stage 1 is full
// and cannot move; arst_n puts every key in the released phase
// ----------------------------------------------------------------------------
module key_click_classifier import kcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	kcc_in_if.sink                in_ch,
	kcc_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg;
	key_rec_t          key_q [NUM_KEYS];

	logic              valid_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] time_s1;

	logic              valid_s2;
	logic [KEY_W-1:0]  key_s2;
	event_t            ev_s2;
	logic              pressed_s2;

	logic              advance;
	logic              in_range;
	logic              lvl;
	key_rec_t          rec_cur;
	key_rec_t          rec_nxt;
	event_t            ev;

	kcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			key_s1  <= in_ch.key_index;
			pin_s1  <= in_ch.pin_level;
			time_s1 <= in_ch.time_ms;
		end
	end

	// record select
	always_comb begin
		in_range = 1'b0;
		rec_cur  = KEY_REC_RESET;
		for (int k = 0; k < NUM_KEYS; k++) begin
			if (int'(key_s1) == k) begin
				in_range = 1'b1;
				rec_cur  = key_q[k];
			end
		end
	end

	assign lvl = pin_s1 ^ cfg.active_low_mask[key_s1];

	kcc_key_step u_step (
		.rec     (rec_cur),
		.lvl     (lvl),
		.now     (time_s1),
		.cfg     (cfg),
		.rec_nxt (rec_nxt),
		.ev      (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				key_q[k] <= KEY_REC_RESET;
			end
		end else if (advance) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (int'(key_s1) == k) begin
					key_q[k] <= rec_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_s2     <= key_s1;
			ev_s2      <= in_range ? ev : EV_NONE;
			pressed_s2 <= in_range && rec_nxt.stable_pressed;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.key_out    = key_s2;
	assign out_ch.event_res  = ev_s2;
	assign out_ch.is_pressed = pressed_s2;

endmodule
